// ----- hw/rtl/psrfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Reply frame parser package
// Shared item and result types, frame layout constants and the status remap.
// ----------------------------------------------------------------------------
package psrfp_pkg;

    localparam logic [7:0] END_MARK      = 8'hff;
    localparam logic [7:0] CMD_STATE     = 8'haa;
    localparam logic [7:0] RC_OK         = 8'h00;

    localparam int unsigned POS_LEN       = 4;
    localparam int unsigned POS_FIRST_END = 5;
    localparam int unsigned POS_CODE      = 9;
    localparam int unsigned POS_CMD       = 10;
    localparam int unsigned POS_STAT      = 11;
    localparam int unsigned POS_STAT_LAST = 14;
    localparam int unsigned POS_CURR      = 15;
    localparam int unsigned POS_CURR_LAST = 18;

    localparam logic [7:0] MIN_LEN       = 8'd6;
    localparam logic [7:0] MIN_STATE_LEN = 8'd19;

    localparam logic [31:0] MASK_RUN   = 32'h0000_0002;
    localparam logic [31:0] MASK_RELAY = 32'h0000_0004;
    localparam logic [31:0] MASK_LOAD  = 32'h0000_0010;
    localparam logic [31:0] MASK_WATER = 32'h0000_0040;
    localparam logic [31:0] MASK_IGBT  = 32'h3fc0_0000;
    localparam logic [31:0] MASK_DOOR  = 32'h4000_0000;
    localparam logic [31:0] MASK_RAMP  = 32'h0000_8000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic        frame_valid;
        logic        status_updated;
        logic [7:0]  return_code;
        logic [6:0]  ps_status;
        logic [31:0] current_bits;
    } result_t;

    function automatic logic [6:0] remap_status(input logic [31:0] w);
        logic [6:0] f;
        f[0] = |(w & MASK_RUN);
        f[1] = |(w & MASK_RELAY);
        f[2] = |(w & MASK_LOAD);
        f[3] = |(w & MASK_WATER);
        f[4] = |(w & MASK_IGBT);
        f[5] = |(w & MASK_DOOR);
        f[6] = |(w & MASK_RAMP);
        return f;
    endfunction

endpackage

// ----- hw/rtl/psrfp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Reply frame parser input register
// Holds one accepted byte item until the parser takes it.
// ----------------------------------------------------------------------------
module psrfp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  psrfp_pkg::item_t   in_item,
    input  logic               advance,
    output logic               item_valid,
    output psrfp_pkg::item_t   item
);

    logic             valid_reg;
    logic             valid_next;
    psrfp_pkg::item_t item_reg;
    logic             accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        priority if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- hw/rtl/psrfp_parse.sv -----
// ----------------------------------------------------------------------------
// Reply frame parser core
// Tracks the byte position, captures the frame fields and decides the result
// at the last byte or at a bad length byte.
// ----------------------------------------------------------------------------
module psrfp_parse #(
    parameter int unsigned MAX_FRAME = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  psrfp_pkg::item_t    item,
    output logic                emit,
    output psrfp_pkg::result_t  res
);

    localparam int unsigned IDX_W   = $clog2(MAX_FRAME);
    localparam logic [7:0]  MAX_LEN = 8'(MAX_FRAME);

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic             in_frame_reg, in_frame_next;
    logic [7:0]       frame_length_reg, frame_length_next;
    logic             head_ok_reg, head_ok_next;
    logic [7:0]       reply_code_reg, reply_code_next;
    logic [7:0]       command_code_reg, command_code_next;
    logic [31:0]      raw_status_reg, raw_status_next;
    logic [31:0]      raw_current_reg, raw_current_next;
    logic [6:0]       held_status_reg, held_status_next;
    logic [31:0]      held_current_reg, held_current_next;

    logic [IDX_W-1:0] pos;
    logic [7:0]       b;
    logic             start;
    logic             act;
    logic [7:0]       new_len;
    logic             new_head;
    logic [7:0]       new_reply;
    logic [7:0]       new_cmd;
    logic [31:0]      new_stat;
    logic [31:0]      new_curr;
    logic [1:0]       lane_stat;
    logic [1:0]       lane_curr;
    logic             good;
    logic             upd;
    logic             finish;

    assign b         = item.rx_byte;
    assign start     = item.frame_start;
    assign act       = fire && (start || in_frame_reg);
    assign pos       = start ? '0 : byte_index_reg;
    assign lane_stat = 2'(pos - IDX_W'(psrfp_pkg::POS_STAT));
    assign lane_curr = 2'(pos - IDX_W'(psrfp_pkg::POS_CURR));

    always_comb
    begin
        new_len   = start ? 8'd0  : frame_length_reg;
        new_head  = start ? (b == psrfp_pkg::END_MARK) : head_ok_reg;
        new_reply = start ? 8'd0  : reply_code_reg;
        new_cmd   = start ? 8'd0  : command_code_reg;
        new_stat  = start ? 32'd0 : raw_status_reg;
        new_curr  = start ? 32'd0 : raw_current_reg;

        priority if (pos == IDX_W'(psrfp_pkg::POS_LEN))
        begin
            new_len = b;
        end
        else if (pos == IDX_W'(psrfp_pkg::POS_CODE))
        begin
            new_reply = b;
        end
        else if (pos == IDX_W'(psrfp_pkg::POS_CMD))
        begin
            new_cmd = b;
        end
        else if (pos >= IDX_W'(psrfp_pkg::POS_STAT) && pos <= IDX_W'(psrfp_pkg::POS_STAT_LAST))
        begin
            new_stat = new_stat | (32'(b) << {lane_stat, 3'b000});
        end
        else if (pos >= IDX_W'(psrfp_pkg::POS_CURR) && pos <= IDX_W'(psrfp_pkg::POS_CURR_LAST))
        begin
            new_curr = new_curr | (32'(b) << {lane_curr, 3'b000});
        end
        else
        begin
            new_len = new_len;
        end

        good   = new_head && (b == psrfp_pkg::END_MARK);
        upd    = good && (new_reply == psrfp_pkg::RC_OK) &&
                 (new_cmd == psrfp_pkg::CMD_STATE) && (new_len >= psrfp_pkg::MIN_STATE_LEN);
        finish = (pos >= IDX_W'(psrfp_pkg::POS_FIRST_END)) && ((8'(pos) + 8'd1) == new_len);

        byte_index_next   = byte_index_reg;
        in_frame_next     = in_frame_reg;
        frame_length_next = frame_length_reg;
        head_ok_next      = head_ok_reg;
        reply_code_next   = reply_code_reg;
        command_code_next = command_code_reg;
        raw_status_next   = raw_status_reg;
        raw_current_next  = raw_current_reg;
        held_status_next  = held_status_reg;
        held_current_next = held_current_reg;

        emit                = 1'b0;
        res.frame_valid     = 1'b0;
        res.status_updated  = 1'b0;
        res.return_code     = 8'd0;

        if (act)
        begin
            priority if (pos == IDX_W'(psrfp_pkg::POS_LEN) &&
                         (b < psrfp_pkg::MIN_LEN || b > MAX_LEN))
            begin
                emit = 1'b1;
            end
            else if (finish)
            begin
                emit               = 1'b1;
                res.frame_valid    = good;
                res.status_updated = upd;
                res.return_code    = new_reply;
                if (upd)
                begin
                    held_status_next  = psrfp_pkg::remap_status(new_stat);
                    held_current_next = new_curr;
                end
            end
            else
            begin
                byte_index_next   = pos + 1'b1;
                in_frame_next     = 1'b1;
                frame_length_next = new_len;
                head_ok_next      = new_head;
                reply_code_next   = new_reply;
                command_code_next = new_cmd;
                raw_status_next   = new_stat;
                raw_current_next  = new_curr;
            end

            if (emit)
            begin
                byte_index_next   = '0;
                in_frame_next     = 1'b0;
                frame_length_next = 8'd0;
                head_ok_next      = 1'b0;
                reply_code_next   = 8'd0;
                command_code_next = 8'd0;
                raw_status_next   = 32'd0;
                raw_current_next  = 32'd0;
            end
        end

        res.ps_status    = held_status_next;
        res.current_bits = held_current_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            in_frame_reg     <= 1'b0;
            frame_length_reg <= 8'd0;
            head_ok_reg      <= 1'b0;
            reply_code_reg   <= 8'd0;
            command_code_reg <= 8'd0;
            raw_status_reg   <= 32'd0;
            raw_current_reg  <= 32'd0;
            held_status_reg  <= 7'd0;
            held_current_reg <= 32'd0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            in_frame_reg     <= in_frame_next;
            frame_length_reg <= frame_length_next;
            head_ok_reg      <= head_ok_next;
            reply_code_reg   <= reply_code_next;
            command_code_reg <= command_code_next;
            raw_status_reg   <= raw_status_next;
            raw_current_reg  <= raw_current_next;
            held_status_reg  <= held_status_next;
            held_current_reg <= held_current_next;
        end
    end

    // A refresh of the held values only ever comes from a frame with good markers.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (res.frame_valid || !res.status_updated))
        else $error("status update without a valid frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit) |=> !in_frame_reg)
        else $error("frame still open after its result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (byte_index_reg == '0))
        else $error("byte position left over outside a frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !emit) |=> ($stable(held_status_reg) && $stable(held_current_reg)))
        else $error("held values changed without a result");

endmodule

// ----- hw/rtl/psrfp_out_stage.sv -----
// ----------------------------------------------------------------------------
// Reply frame parser result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module psrfp_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  psrfp_pkg::result_t  res,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_stall,
    output psrfp_pkg::result_t  out_res
);

    logic               valid_reg;
    logic               valid_next;
    psrfp_pkg::result_t res_reg;

    assign busy      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- hw/rtl/ps_reply_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Power-supply reply frame parser
// Parses reply frames byte by byte, one result per finished or aborted frame.
// ----------------------------------------------------------------------------
// The block takes one reply byte per clock cycle while no stalled receiver
// holds a result. A byte is held in the input register, and the parser then
// writes the frame result into the result register, which drives the
// output. The input register moves on only when the result register is
// empty or is being taken in the same cycle. While a stalled receiver holds
// a result, the byte in the input register waits, whether or not it
// finishes a frame, and the input stalls until the result is taken.
// ----------------------------------------------------------------------------
module ps_reply_frame_parser #(
    parameter int unsigned MAX_FRAME = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_valid,
    output logic        status_updated,
    output logic [7:0]  return_code,
    output logic [6:0]  ps_status,
    output logic [31:0] current_bits
);

    psrfp_pkg::item_t   in_item;
    psrfp_pkg::item_t   item;
    psrfp_pkg::result_t res;
    psrfp_pkg::result_t out_res;
    logic               item_valid;
    logic               busy;
    logic               fire;
    logic               emit;

    assign in_item.rx_byte     = rx_byte;
    assign in_item.frame_start = frame_start;
    assign fire                = item_valid && !busy;

    psrfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    psrfp_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .emit  (emit),
        .res   (res)
    );

    psrfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && emit),
        .res       (res),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign frame_valid    = out_res.frame_valid;
    assign status_updated = out_res.status_updated;
    assign return_code    = out_res.return_code;
    assign ps_status      = out_res.ps_status;
    assign current_bits   = out_res.current_bits;

endmodule
